/* src/assert_macros.svh */
// Assertion helpers used by the checker file idwn_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("implication check failed");

// Next-cycle implication, inactive while reset is asserted.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

/* src/idwn_pkg.sv */
package idwn_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_LIST  = 2'd0;
	localparam logic [1:0] KIND_DELAY = 2'd1;
	localparam logic [1:0] KIND_FWD   = 2'd2;

	localparam int FACE_W  = 16;
	localparam int DELAY_W = 16;

	// One table entry as held by a cell.
	typedef struct packed {
		logic               valid;
		logic               seen;
		logic               kill;
		logic [FACE_W-1:0]  face;
		logic [DELAY_W-1:0] delay;
	} entry_t;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		OP_HOLD   = 3'd0,
		OP_INSERT = 3'd1,
		OP_SEEN   = 3'd2,
		OP_KILL   = 3'd3,
		OP_PRUNE  = 3'd4,
		OP_REMOVE = 3'd5
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [FACE_W-1:0]  id;
		logic [DELAY_W-1:0] delay;
		logic               seen;
	} ctl_t;

endpackage

/* src/inverse_delay_weighted_next_hop_select.sv */
// A list item passes ST_LIST; one that closes a list then marks unseen faces in ST_PMARK
// and removes them one at a time in ST_PRUNE. A delay report marks its face in ST_DMARK and,
// if present, removes it in ST_DREMOVE and reinserts it in ST_DINSERT. A forward request
// passes ST_FSETUP, ST_FSCALE, a walk in rank order in ST_FWALK, one entry per cycle, and
// ST_FOUT, which waits while a held result is not taken. One item at a time: in_stall is high until idle.
// Reset: asynchronous, active low; the table empties, the delay total clears to zero.
module inverse_delay_weighted_next_hop_select #(
	parameter int MAX_FACES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] face_id,
	input  logic        last_in_list,
	input  logic [15:0] delay_ms,
	input  logic [31:0] random_word,
	input  logic [15:0] blocked_face_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] chosen_face_id,
	output logic        found
);
	import idwn_pkg::*;

	localparam int IDXW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
	localparam int CW   = $clog2(MAX_FACES + 1);
	localparam int TW   = DELAY_W + $clog2(MAX_FACES);
	localparam int IW   = TW + $clog2(MAX_FACES);
	localparam int PW   = 33 + IW;

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b00000000001,
		ST_LIST    = 11'b00000000010,
		ST_PMARK   = 11'b00000000100,
		ST_PRUNE   = 11'b00000001000,
		ST_DMARK   = 11'b00000010000,
		ST_DREMOVE = 11'b00000100000,
		ST_DINSERT = 11'b00001000000,
		ST_FSETUP  = 11'b00010000000,
		ST_FSCALE  = 11'b00100000000,
		ST_FWALK   = 11'b01000000000,
		ST_FOUT    = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [15:0]   id_q, delay_q, blocked_q;
	logic          last_q, dseen_q;
	logic [31:0]   rnd_q;
	logic [CW-1:0] count_q, r_q;
	logic [TW-1:0] total_q;
	logic [IW-1:0] inv_q, sel_q, cum_q;
	logic [15:0]   res_face_q, out_face_q;
	logic          res_found_q, out_found_q, out_valid_q;

	ctl_t   ctl;
	entry_t cd [MAX_FACES];
	logic   pl [MAX_FACES];
	logic   kp [MAX_FACES];
	logic   mt [MAX_FACES];
	logic   fk [MAX_FACES];

	// Chain of cells, each handing its entry to both neighbours.
	for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
		entry_t ld, rd;
		logic   lp, lk;
		if (i == 0) begin : g_first
			assign ld = '0;
			assign lp = 1'b0;
			assign lk = 1'b0;
		end else begin : g_mid
			assign ld = cd[i-1];
			assign lp = pl[i-1];
			assign lk = kp[i-1];
		end
		if (i == MAX_FACES - 1) begin : g_last
			assign rd = '0;
		end else begin : g_inner
			assign rd = cd[i+1];
		end
		idwn_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left_d     (ld),
			.right_d    (rd),
			.left_place (lp),
			.left_kpre  (lk),
			.d          (cd[i]),
			.place      (pl[i]),
			.kpre       (kp[i]),
			.match      (mt[i]),
			.first_kill (fk[i])
		);
	end

	// Match and removal summaries gathered across the chain.
	logic        match_any, match_seen, any_kill;
	logic [15:0] kill_delay;
	always_comb begin
		match_any  = 1'b0;
		match_seen = 1'b0;
		any_kill   = 1'b0;
		kill_delay = '0;
		for (int i = 0; i < MAX_FACES; i++) begin
			match_any  = match_any | mt[i];
			match_seen = match_seen | (mt[i] & cd[i].seen);
			any_kill   = any_kill | fk[i];
			kill_delay = kill_delay | (fk[i] ? cd[i].delay : 16'd0);
		end
	end

	logic full;
	assign full = (count_q == CW'(MAX_FACES));

	// Operation for the cells in each state.
	always_comb begin
		ctl.op    = OP_HOLD;
		ctl.id    = id_q;
		ctl.delay = delay_q;
		ctl.seen  = dseen_q;
		unique case (state_q)
			ST_LIST: begin
				ctl.delay = '0;
				ctl.seen  = 1'b1;
				if (match_any) ctl.op = OP_SEEN;
				else if (!full) ctl.op = OP_INSERT;
			end
			ST_PMARK:   ctl.op = OP_PRUNE;
			ST_PRUNE:   ctl.op = any_kill ? OP_REMOVE : OP_HOLD;
			ST_DMARK:   ctl.op = OP_KILL;
			ST_DREMOVE: ctl.op = OP_REMOVE;
			ST_DINSERT: ctl.op = OP_INSERT;
			default:    ctl.op = OP_HOLD;
		endcase
	end

	// Walk arithmetic for the entry at the current rank.
	entry_t        wr;
	logic [IW-1:0] cum_n;
	logic [PW-1:0] prod;
	logic          hit;
	assign wr    = cd[r_q[IDXW-1:0]];
	assign cum_n = cum_q + IW'(total_q - TW'(wr.delay));
	assign hit   = (sel_q <= cum_n) && (wr.face != blocked_q);
	assign prod  = PW'(rnd_q) * PW'({1'b0, inv_q} + (IW+1)'(1));

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FOUT) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						id_q      <= face_id;
						last_q    <= last_in_list;
						delay_q   <= delay_ms;
						rnd_q     <= random_word;
						blocked_q <= blocked_face_id;
						unique case (kind)
							KIND_LIST:  state_q <= ST_LIST;
							KIND_DELAY: state_q <= ST_DMARK;
							KIND_FWD:   state_q <= ST_FSETUP;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LIST: begin
					if (!match_any && !full) count_q <= count_q + CW'(1);
					state_q <= last_q ? ST_PMARK : ST_IDLE;
				end
				ST_PMARK: state_q <= ST_PRUNE;
				ST_PRUNE: begin
					if (any_kill) begin
						total_q <= total_q - TW'(kill_delay);
						count_q <= count_q - CW'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DMARK: begin
					dseen_q <= match_seen;
					state_q <= match_any ? ST_DREMOVE : ST_IDLE;
				end
				ST_DREMOVE: begin
					total_q <= total_q - TW'(kill_delay);
					count_q <= count_q - CW'(1);
					state_q <= ST_DINSERT;
				end
				ST_DINSERT: begin
					total_q <= total_q + TW'(delay_q);
					count_q <= count_q + CW'(1);
					state_q <= ST_IDLE;
				end
				ST_FSETUP: begin
					inv_q   <= (count_q == '0) ? '0
					           : IW'(IW'(count_q - CW'(1)) * IW'(total_q));
					state_q <= ST_FSCALE;
				end
				ST_FSCALE: begin
					sel_q   <= prod[32 +: IW];
					r_q     <= '0;
					cum_q   <= '0;
					state_q <= ST_FWALK;
				end
				ST_FWALK: begin
					if (r_q >= count_q) begin
						res_face_q  <= '0;
						res_found_q <= 1'b0;
						state_q     <= ST_FOUT;
					end else if (hit) begin
						res_face_q  <= wr.face;
						res_found_q <= 1'b1;
						state_q     <= ST_FOUT;
					end else begin
						cum_q <= cum_n;
						r_q   <= r_q + CW'(1);
					end
				end
				ST_FOUT: begin
					if (!out_valid_q || !out_stall) begin
						out_face_q  <= res_face_q;
						out_found_q <= res_found_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign chosen_face_id = out_face_q;
	assign found          = out_found_q;

endmodule

/* src/idwn_cell.sv */
module idwn_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  idwn_pkg::ctl_t  ctl,
	input  idwn_pkg::entry_t left_d,
	input  idwn_pkg::entry_t right_d,
	input  logic            left_place,
	input  logic            left_kpre,
	output idwn_pkg::entry_t d,
	output logic            place,
	output logic            kpre,
	output logic            match,
	output logic            first_kill
);
	import idwn_pkg::*;

	entry_t ent_q;
	entry_t nxt;

	assign d = ent_q;

	// The chain is packed and sorted by (delay, face), so place and kpre are monotonic.
	assign place      = !ent_q.valid || ({ent_q.delay, ent_q.face} > {ctl.delay, ctl.id});
	assign match      = ent_q.valid && (ent_q.face == ctl.id);
	assign kpre       = left_kpre || (ent_q.valid && ent_q.kill);
	assign first_kill = ent_q.valid && ent_q.kill && !left_kpre;

	// Next contents: hold, take a neighbour, take the new entry or update flags.
	always_comb begin
		nxt = ent_q;
		unique case (ctl.op)
			OP_HOLD: begin
				nxt = ent_q;
			end
			OP_INSERT: begin
				if (left_place) begin
					nxt = left_d;
				end else if (place) begin
					nxt.valid = 1'b1;
					nxt.seen  = ctl.seen;
					nxt.kill  = 1'b0;
					nxt.face  = ctl.id;
					nxt.delay = ctl.delay;
				end
			end
			OP_SEEN: begin
				if (match) nxt.seen = 1'b1;
			end
			OP_KILL: begin
				if (match) nxt.kill = 1'b1;
			end
			OP_PRUNE: begin
				nxt.kill = ent_q.valid && !ent_q.seen;
				nxt.seen = 1'b0;
			end
			OP_REMOVE: begin
				if (kpre) nxt = right_d;
			end
			default: begin
				nxt = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= nxt;
		end
	end

endmodule

/* src/idwn_chk.sv */
`include "assert_macros.svh"

module idwn_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] chosen_face_id,
	input logic        found
);

	// A held result keeps its value until taken.
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(chosen_face_id) && $stable(found))

	// A rejected request carries face zero.
	`ASSERT_IMPL(a_zero, clk, arst_n, out_valid && !found, chosen_face_id == 16'd0)

	// A new result only appears after the block has been busy with a request.
	`ASSERT_IMPL(a_busy, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind inverse_delay_weighted_next_hop_select idwn_chk u_idwn_chk (.*);
